### design/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg
// Shared operation codes and the flag group that travels with each item
// from the front end through the queue to the reduction engine.
// ----------------------------------------------------------------------------
package rar_pkg;

	// operation codes
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	// status codes
	localparam logic ST_OK     = 1'b0;
	localparam logic ST_DIVZER = 1'b1;

	// per-item classification
	typedef struct packed {
		logic neg;   // numerator is negative
		logic bad;   // zero denominator, answer 0/1 with error
		logic zero;  // zero numerator, answer 0/1
	} rar_flags_t;

	localparam int FLAGS_W = $bits(rar_flags_t);

endpackage

### design/rational_arithmetic_reduce.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_reduce
// Fraction add, subtract, multiply and divide with reduction to lowest terms.
// ----------------------------------------------------------------------------
// Usage: drive op, a_num, a_den, b_num, b_den and raise start; the item
// transfers at a clock edge where start is high and busy is low.
// One result per item is marked by done, high for exactly one cycle, on
// res_num, res_den and status; the receiver cannot stall, so it must take it.
// Flow: the front end registers the cross products, then the numerator,
// denominator and error flag; the item then waits in a two-entry queue
// for the reduction engine. Reduction runs one binary gcd step per cycle
// (shifts plus subtractions), then the two bit-serial divisions by the
// gcd on a shared divider. Zero and error items skip the gcd and the
// divisions. The front end holds one item at a time and takes a new one
// only after pushing the last and while the queue is not full; sustained
// rate is set by the reduction engine.
// Reset clears the queue and all control; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rational_arithmetic_reduce import rar_pkg::*; #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               op,
	input  logic [OPERAND_WIDTH-1:0] a_num,
	input  logic [OPERAND_WIDTH-2:0] a_den,
	input  logic [OPERAND_WIDTH-1:0] b_num,
	input  logic [OPERAND_WIDTH-2:0] b_den,
	output logic                     done,
	output logic [31:0]              res_num,
	output logic [30:0]              res_den,
	output logic                     status
);

	localparam int VW = 2*OPERAND_WIDTH-1;
	localparam int DW = FLAGS_W + 2*VW;

	logic          push, pop, q_empty, q_full;
	rar_flags_t    push_flags, q_flags;
	logic [VW-1:0] push_mag, push_den, q_mag, q_den;
	logic [DW-1:0] q_rdata;

	// front end: accept and classify
	rar_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.a_num      (a_num),
		.a_den      (a_den),
		.b_num      (b_num),
		.b_den      (b_den),
		.q_full     (q_full),
		.push       (push),
		.push_flags (push_flags),
		.push_mag   (push_mag),
		.push_den   (push_den)
	);

	// queue between front and back
	rar_queue #(.DATA_W(DW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({push_flags, push_mag, push_den}),
		.pop    (pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.full   (q_full)
	);

	assign {q_flags, q_mag, q_den} = q_rdata;

	// reduction engine
	rar_back #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_flags (q_flags),
		.q_mag   (q_mag),
		.q_den   (q_den),
		.pop     (pop),
		.done    (done),
		.res_num (res_num),
		.res_den (res_den),
		.status  (status)
	);

endmodule

### design/rar_front.sv
// ----------------------------------------------------------------------------
// rar_front
// Accepts an item, forms the cross products and the unreduced numerator
// and denominator, classifies the item and pushes it into the queue.
// ----------------------------------------------------------------------------
module rar_front import rar_pkg::*; #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 op,
	input  logic [OPERAND_WIDTH-1:0]   a_num,
	input  logic [OPERAND_WIDTH-2:0]   a_den,
	input  logic [OPERAND_WIDTH-1:0]   b_num,
	input  logic [OPERAND_WIDTH-2:0]   b_den,
	input  logic                       q_full,
	output logic                       push,
	output rar_flags_t                 push_flags,
	output logic [2*OPERAND_WIDTH-2:0] push_mag,
	output logic [2*OPERAND_WIDTH-2:0] push_den
);

	localparam int W  = OPERAND_WIDTH;
	localparam int VW = 2*W-1;
	localparam int PW = 2*W+1;

	logic                 v_s1, v_s2;
	logic [1:0]           op_s1;
	logic                 bneg_s1;
	logic signed [PW-1:0] pa_s1, pb_s1;
	logic [VW-1:0]        pc_s1;
	logic signed [PW-1:0] num_s2;
	logic                 bad_s2;
	logic [VW-1:0]        den_s2;

	logic signed [W:0]     a_x, b_x, ad_x, mula;
	logic signed [2*W+1:0] pa, pb;
	logic [W-1:0]          bn_mag, mulc;
	logic [VW-1:0]         pc;
	logic signed [PW-1:0]  num_d, num_neg;
	logic                  take;

	// one item in flight in the front end at a time
	assign busy = v_s1 | v_s2 | q_full;
	assign take = start & ~busy;

	// operand selection and products
	always_comb begin
		a_x    = {a_num[W-1], a_num};
		b_x    = {b_num[W-1], b_num};
		ad_x   = {2'b00, a_den};
		mula   = (op == OP_MUL) ? b_x : $signed({2'b00, b_den});
		pa     = a_x * mula;
		pb     = b_x * ad_x;
		bn_mag = b_num[W-1] ? (~b_num + 1'b1) : b_num;
		mulc   = (op == OP_DIV) ? bn_mag : {1'b0, b_den};
		pc     = {{W{1'b0}}, a_den} * {{(W-1){1'b0}}, mulc};
	end

	// stage 1: registered products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1   <= op;
			bneg_s1 <= b_num[W-1];
			pa_s1   <= pa[PW-1:0];
			pb_s1   <= pb[PW-1:0];
			pc_s1   <= pc;
		end
	end

	// combine products per operation
	always_comb begin
		num_neg = -pa_s1;
		case (op_s1)
			OP_ADD:  num_d = pa_s1 + pb_s1;
			OP_SUB:  num_d = pa_s1 - pb_s1;
			OP_MUL:  num_d = pa_s1;
			default: num_d = bneg_s1 ? num_neg : pa_s1;
		endcase
	end

	// stage 2: numerator, denominator, error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			num_s2 <= num_d;
			den_s2 <= pc_s1;
			bad_s2 <= (pc_s1 == '0);
		end
	end

	// classify and push; the queue always has room here
	always_comb begin
		push            = v_s2;
		push_flags.neg  = num_s2[PW-1];
		push_flags.bad  = bad_s2;
		push_flags.zero = (num_s2 == '0);
		push_mag        = num_s2[PW-1] ? VW'(-num_s2) : VW'(num_s2);
		push_den        = den_s2;
	end

endmodule

### design/rar_queue.sv
// ----------------------------------------------------------------------------
// rar_queue
// Two-entry queue between the front end and the reduction engine.
// ----------------------------------------------------------------------------
module rar_queue #(
	parameter int DATA_W = 65
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wdata,
	input  logic              pop,
	output logic [DATA_W-1:0] rdata,
	output logic              empty,
	output logic              full
);

	logic [DATA_W-1:0] entry_q [2];
	logic              wr_ptr_q, rd_ptr_q;
	logic [1:0]        count_q;

	assign empty = (count_q == 2'd0);
	assign full  = (count_q == 2'd2);
	assign rdata = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= wdata;
	end

endmodule

### design/rar_back.sv
// ----------------------------------------------------------------------------
// rar_back
// Reduction engine: binary gcd of magnitude and denominator, then two
// exact divisions by the gcd on a shared bit-serial divider.
// ----------------------------------------------------------------------------
module rar_back import rar_pkg::*; #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	input  rar_flags_t                 q_flags,
	input  logic [2*OPERAND_WIDTH-2:0] q_mag,
	input  logic [2*OPERAND_WIDTH-2:0] q_den,
	output logic                       pop,
	output logic                       done,
	output logic [31:0]                res_num,
	output logic [30:0]                res_den,
	output logic                       status
);

	localparam int VW = 2*OPERAND_WIDTH-1;
	localparam int KW = $clog2(VW+1);
	localparam int EW = (VW+1 > 32) ? VW+1 : 32;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_GCD  = 3'b010,
		S_DIV  = 3'b100
	} state_t;

	state_t        state_q;
	logic [VW-1:0] u_q, v_q, g_q, mag_q, den_q, quo_q, rem_q;
	logic [KW-1:0] k_q, cnt_q;
	logic          neg_q, sel_q, done_q, status_q;
	logic [31:0]   res_num_q;
	logic [30:0]   res_den_q;

	logic [VW:0]          trial;
	logic                 ge;
	logic [VW-1:0]        quo_n;
	logic signed [VW:0]   sn;
	logic signed [EW-1:0] sn_ext;
	logic [EW-1:0]        den_ext;

	assign pop     = (state_q == S_IDLE) & ~q_empty;
	assign done    = done_q;
	assign res_num = res_num_q;
	assign res_den = res_den_q;
	assign status  = status_q;

	// divider step and result formatting
	always_comb begin
		trial   = {rem_q, quo_q[VW-1]};
		ge      = (trial >= {1'b0, g_q});
		quo_n   = {quo_q[VW-2:0], ge};
		sn      = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
		sn_ext  = EW'(sn);
		den_ext = EW'(quo_n);
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						if (q_flags.bad || q_flags.zero) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_GCD;
						end
					end
				end
				S_GCD: begin
					if (u_q == '0) state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == KW'(1) && sel_q) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				u_q   <= q_mag;
				v_q   <= q_den;
				mag_q <= q_mag;
				den_q <= q_den;
				neg_q <= q_flags.neg;
				k_q   <= '0;
				if (!q_empty) begin
					res_num_q <= '0;
					res_den_q <= 31'd1;
					status_q  <= q_flags.bad ? ST_DIVZER : ST_OK;
				end
			end
			S_GCD: begin
				if (u_q == '0) begin
					g_q   <= v_q << k_q;
					quo_q <= mag_q;
					rem_q <= '0;
					cnt_q <= KW'(VW);
					sel_q <= 1'b0;
				end else if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (u_q >= v_q) begin
					u_q <= u_q - v_q;
				end else begin
					v_q <= v_q - u_q;
				end
			end
			S_DIV: begin
				rem_q <= ge ? VW'(trial - {1'b0, g_q}) : trial[VW-1:0];
				quo_q <= quo_n;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == KW'(1)) begin
					if (!sel_q) begin
						mag_q <= quo_n;
						quo_q <= den_q;
						rem_q <= '0;
						cnt_q <= KW'(VW);
						sel_q <= 1'b1;
					end else begin
						res_num_q <= sn_ext[31:0];
						res_den_q <= den_ext[30:0];
						status_q  <= ST_OK;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rational_arithmetic_reduce: a directed table of
// edge cases, then random fractions checked against a fraction predictor.
// ----------------------------------------------------------------------------
module testbench;
	import rar_pkg::*;

	localparam int W         = 16;
	localparam int N_RANDOM  = 1330;
	localparam int IDLE_LIM  = 20000;
	localparam int TAIL_CYC  = 300;

	typedef struct {
		logic [1:0]   op;
		logic [W-1:0] an;
		logic [W-2:0] ad;
		logic [W-1:0] bn;
		logic [W-2:0] bd;
		logic         known;
		logic [31:0]  rn;
		logic [30:0]  rd;
		logic         st;
	} frac_row_t;

	typedef struct {
		logic [31:0] rn;
		logic [30:0] rd;
		logic        st;
	} frac_res_t;

	logic         clk;
	logic         arst_n;
	logic         start;
	logic         busy;
	logic [1:0]   op;
	logic [W-1:0] a_num;
	logic [W-2:0] a_den;
	logic [W-1:0] b_num;
	logic [W-2:0] b_den;
	logic         done;
	logic [31:0]  res_num;
	logic [30:0]  res_den;
	logic         status;

	frac_res_t expected_q[$];
	frac_row_t rows[$];
	int        mismatches;
	int        idle_cycles;
	int        send_idle_pct;
	logic      timed_out;

	rational_arithmetic_reduce #(.OPERAND_WIDTH(W)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.done(done), .res_num(res_num), .res_den(res_den), .status(status)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// fraction result, reduced to lowest terms
	function automatic frac_res_t reduce_frac(input frac_row_t r);
		frac_res_t res;
		longint an, ad, bn, bd, num, den, x, y, t;
		logic bad;
		an = longint'($signed(r.an));
		ad = longint'(r.ad);
		bn = longint'($signed(r.bn));
		bd = longint'(r.bd);
		bad = 1'b0;
		case (r.op)
			OP_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
			OP_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
			OP_MUL: begin num = an * bn; den = ad * bd; end
			default: begin
				if (bn < 0) begin num = -an * bd; den = ad * -bn; end
				else begin num = an * bd; den = ad * bn; end
				if (bn == 0) bad = 1'b1;
			end
		endcase
		if (den == 0) bad = 1'b1;
		if (bad || num == 0) begin
			res.rn = 32'd0;
			res.rd = 31'd1;
		end else begin
			x = (num < 0) ? -num : num;
			y = den;
			while (y != 0) begin t = x % y; x = y; y = t; end
			num = num / x;
			den = den / x;
			res.rn = num[31:0];
			res.rd = den[30:0];
		end
		res.st = bad ? ST_DIVZER : ST_OK;
		return res;
	endfunction

	function automatic frac_row_t mk(input logic [1:0] o, input int an, input int ad,
			input int bn, input int bd);
		frac_row_t r;
		r.op = o; r.an = an[W-1:0]; r.ad = ad[W-2:0];
		r.bn = bn[W-1:0]; r.bd = bd[W-2:0]; r.known = 1'b0;
		r.rn = '0; r.rd = '0; r.st = ST_OK;
		return r;
	endfunction

	function automatic frac_row_t mk_known(input frac_row_t r, input int rn, input int rd,
			input logic st);
		r.known = 1'b1; r.rn = rn; r.rd = rd[30:0]; r.st = st;
		return r;
	endfunction

	// random fraction; mostly full range, some small or extreme values
	function automatic frac_row_t rand_row();
		frac_row_t r;
		int k;
		r = mk(2'($urandom_range(0, 3)), 0, 1, 0, 1);
		k = $urandom_range(0, 9);
		r.an = (k < 5) ? W'($urandom) : (k < 8) ? W'($urandom_range(0, 24) - 12)
			: ((k == 8) ? 16'h8000 : 16'h7fff);
		k = $urandom_range(0, 9);
		r.bn = (k < 5) ? W'($urandom) : (k < 8) ? W'($urandom_range(0, 24) - 12)
			: ((k == 8) ? 16'h8000 : 16'h0000);
		r.ad = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(1, 12)) : 15'($urandom);
		r.bd = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(1, 12)) : 15'($urandom);
		if ($urandom_range(0, 40) == 0) r.ad = '0;
		if ($urandom_range(0, 40) == 0) r.bd = '0;
		return r;
	endfunction

	// one item transfer, honoring the sender idle rate
	task automatic send_item(input frac_row_t r);
		frac_res_t e;
		while ($urandom_range(1, 100) <= send_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		op <= r.op; a_num <= r.an; a_den <= r.ad; b_num <= r.bn; b_den <= r.bd;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		e = r.known ? '{r.rn, r.rd, r.st} : reduce_frac(r);
		expected_q.push_back(e);
		@(negedge clk);
	endtask

	// result check on each accepted result
	always @(posedge clk) begin
		frac_res_t e;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %0d/%0d st %0b", $signed(res_num),
						res_den, status);
			end else begin
				e = expected_q.pop_front();
				if (res_num !== e.rn || res_den !== e.rd || status !== e.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d/%0d st %0b, got %0d/%0d st %0b",
							$signed(e.rn), e.rd, e.st, $signed(res_num), res_den,
							status);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	initial begin
		mismatches = 0; idle_cycles = 0; send_idle_pct = 0; timed_out = 1'b0;
		arst_n = 1'b0; start = 1'b0; op = OP_ADD;
		a_num = '0; a_den = 15'd1; b_num = '0; b_den = 15'd1;
		// directed table
		rows.push_back(mk_known(mk(OP_ADD, 1, 2, 1, 2), 1, 1, ST_OK));
		rows.push_back(mk_known(mk(OP_SUB, 3, 4, 3, 4), 0, 1, ST_OK));
		rows.push_back(mk_known(mk(OP_MUL, 0, 7, -5, 3), 0, 1, ST_OK));
		rows.push_back(mk_known(mk(OP_DIV, 5, 3, 0, 9), 0, 1, ST_DIVZER));
		rows.push_back(mk_known(mk(OP_DIV, 0, 3, 0, 9), 0, 1, ST_DIVZER));
		rows.push_back(mk_known(mk(OP_ADD, 1, 0, 1, 1), 0, 1, ST_DIVZER));
		rows.push_back(mk_known(mk(OP_MUL, 1, 1, 1, 0), 0, 1, ST_DIVZER));
		rows.push_back(mk_known(mk(OP_MUL, -32768, 1, -32768, 1), 1073741824, 1, ST_OK));
		rows.push_back(mk_known(mk(OP_MUL, 32767, 1, -32768, 1), -1073709056, 1, ST_OK));
		rows.push_back(mk_known(mk(OP_MUL, 1, 32767, 1, 32767), 1, 1073676289, ST_OK));
		rows.push_back(mk_known(mk(OP_DIV, 1, 1, -32768, 1), -1, 32768, ST_OK));
		rows.push_back(mk_known(mk(OP_DIV, -6, 1, -3, 1), 2, 1, ST_OK));
		rows.push_back(mk(OP_ADD, 32767, 32767, 32767, 32767));
		rows.push_back(mk(OP_SUB, -32768, 1, 32767, 32767));
		rows.push_back(mk(OP_ADD, -32768, 32766, -32768, 32765));
		rows.push_back(mk(OP_SUB, 32767, 2, -32768, 3));
		rows.push_back(mk(OP_DIV, -32768, 32767, 32767, 1));
		rows.push_back(mk(OP_DIV, 21845, 10922, -10922, 21845));
		rows.push_back(mk(OP_MUL, -1, 1, -1, 1));
		rows.push_back(mk(OP_ADD, 12, 18, -4, 6));
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (rows[i]) send_item(rows[i]);
		start <= 1'b0;
		// pause until all directed results are in
		while (expected_q.size() != 0) @(negedge clk);
		// random part in three idle phases
		for (int n = 0; n < N_RANDOM; n++) begin
			send_idle_pct = (n < N_RANDOM / 3) ? 23 : (n < 2 * N_RANDOM / 3) ? 50 : 0;
			send_item(rand_row());
		end
		start <= 1'b0;
		while (expected_q.size() != 0 && idle_cycles < IDLE_LIM) @(negedge clk);
		if (idle_cycles >= IDLE_LIM) timed_out = 1'b1;
		repeat (TAIL_CYC) @(negedge clk);
		if (mismatches == 0 && !timed_out && expected_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog exit when nothing moves for too long
	initial begin
		wait (idle_cycles >= IDLE_LIM);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### filelist.f
design/rar_pkg.sv
design/rar_front.sv
design/rar_queue.sv
design/rar_back.sv
design/rational_arithmetic_reduce.sv
tb/sv/testbench.sv
